[sv/rs_pkg.sv]
// Shared types and constants for the reservoir sampler.
`default_nettype none
package rs_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned HandleW      = 32;
  localparam int unsigned SlotW        = 6;
  localparam int unsigned SizeW        = 7;
  localparam int unsigned DivBits      = 32;
  localparam int unsigned DivCntW      = $clog2(DivBits + 1);

  localparam logic [SizeW-1:0] SizeReset = SizeW'(64);

  typedef enum logic [0:0] {
    MODE_OFFER = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    KIND_STORE = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_FL_READ,
    ST_FL_EMIT
  } state_e;

endpackage
`default_nettype wire

[sv/rs_divider.sv]
// Restoring modulo unit: one remainder bit per cycle over a 32-bit dividend.
`default_nettype none
module rs_divider (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rs_pkg::DivBits-1:0] dividend_i,
  input  wire logic [rs_pkg::DivBits:0]   divisor_i,
  output logic                          done_o,
  output logic [rs_pkg::DivBits:0]        rem_o
);
  import rs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [DivBits:0]     rem_q, rem_d;
  logic [DivBits-1:0]   dvd_q, dvd_d;
  logic [DivBits:0]     dsr_q, dsr_d;
  logic [DivBits+1:0]   trial;
  logic [DivBits+1:0]   diff;

  assign trial = {rem_q, dvd_q[DivBits-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivBits);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // Keep the trial difference only when it did not go negative.
      rem_d = diff[DivBits+1] ? trial[DivBits:0] : diff[DivBits:0];
      dvd_d = {dvd_q[DivBits-2:0], 1'b0};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[sv/reservoir_sampler.sv]
// Reservoir sampler (Algorithm R) top level with slot memory and sequencer.
//
//   channel | direction | payload
//   --------+-----------+-------------------------------------------
//   in      | sink      | mode_i, record_handle_i, random_value_i
//   cfg     | sink      | sample_size_i
//   out     | source    | kind_o, slot_o, sample_handle_o, last_o
//
// A record taken while the reservoir fills goes straight to the store state.
// Once it is full, a record runs through the bit-serial modulo unit over its
// 32 remainder steps. A flush reads and then emits one slot at a time through
// the single memory read port. Reset clears the count and the sequencer; slot
// contents are undefined until written. A stalled output holds the sequencer
// in place, and no new item is taken until it is done.
`default_nettype none
module reservoir_sampler #(
  parameter int unsigned RESERVOIR_DEPTH = rs_pkg::DefaultDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       mode_i,
  input  wire logic [rs_pkg::HandleW-1:0] record_handle_i,
  input  wire logic [rs_pkg::HandleW-1:0] random_value_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rs_pkg::SizeW-1:0]   sample_size_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            kind_o,
  output logic [rs_pkg::SlotW-1:0]        slot_o,
  output logic [rs_pkg::HandleW-1:0]      sample_handle_o,
  output logic                            last_o
);
  import rs_pkg::*;

  localparam int unsigned AddrW = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
  localparam logic [SizeW-1:0] DepthK = SizeW'(RESERVOIR_DEPTH);

  state_e               state_q, state_d;
  logic [SizeW-1:0]     size_q;
  logic [HandleW-1:0]   count_q, count_d;
  logic [HandleW-1:0]   handle_q, handle_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [SlotW-1:0]     idx_q, idx_d;
  logic [SizeW-1:0]     fl_m_q, fl_m_d;
  logic [HandleW-1:0]   rd_data_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q, out_kind_d;
  logic [SlotW-1:0]     out_slot_q, out_slot_d;
  logic [HandleW-1:0]   out_handle_q, out_handle_d;
  logic                 out_last_q, out_last_d;

  logic [HandleW-1:0]   mem [RESERVOIR_DEPTH];
  logic                 mem_we;
  logic [SizeW-1:0]     k_eff;
  logic                 out_free;
  logic                 fl_last;
  logic                 in_fire;
  logic                 div_start;
  logic                 div_done;
  logic [DivBits:0]     div_rem;

  // Effective sample size: zero reads as one, large values clip to the depth.
  assign k_eff = (size_q == '0) ? SizeW'(1) : ((size_q > DepthK) ? DepthK : size_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fl_last     = ({1'b0, idx_q} + SizeW'(1)) == fl_m_q;

  rs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (random_value_i),
    .divisor_i  ({1'b0, count_q} + (DivBits + 1)'(1)),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    handle_d       = handle_q;
    slot_d         = slot_q;
    idx_d          = idx_q;
    fl_m_d         = fl_m_q;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_kind_d     = out_kind_q;
    out_slot_d     = out_slot_q;
    out_handle_d   = out_handle_q;
    out_last_d     = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          handle_d = record_handle_i;
          if (mode_e'(mode_i) == MODE_FLUSH) begin
            count_d = '0;
            idx_d   = '0;
            fl_m_d  = (count_q < HandleW'(k_eff)) ? count_q[SizeW-1:0] : k_eff;
            state_d = (fl_m_d == '0) ? ST_IDLE : ST_FL_READ;
          end else begin
            if (count_q != '1) begin
              count_d = count_q + HandleW'(1);
            end
            if (count_q < HandleW'(k_eff)) begin
              slot_d  = count_q[SlotW-1:0];
              state_d = ST_STORE;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem < (DivBits + 1)'(k_eff)) begin
            slot_d  = div_rem[SlotW-1:0];
            state_d = ST_STORE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STORE: begin
        if (out_free) begin
          mem_we       = 1'b1;
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_STORE;
          out_slot_d   = slot_q;
          out_handle_d = handle_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_FL_READ: begin
        state_d = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_FLUSH;
          out_slot_d   = idx_q;
          out_handle_d = rd_data_q;
          out_last_d   = fl_last;
          idx_d        = idx_q + SlotW'(1);
          state_d      = fl_last ? ST_IDLE : ST_FL_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SizeReset;
      count_q     <= '0;
      idx_q       <= '0;
      fl_m_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      fl_m_q      <= fl_m_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= sample_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q     <= handle_d;
    slot_q       <= slot_d;
    out_kind_q   <= out_kind_d;
    out_slot_q   <= out_slot_d;
    out_handle_q <= out_handle_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q[AddrW-1:0]] <= handle_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FL_READ) begin
      rd_data_q <= mem[idx_q[AddrW-1:0]];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign slot_o          = out_slot_q;
  assign sample_handle_o = out_handle_q;
  assign last_o          = out_last_q;

endmodule
`default_nettype wire
